// ----- design/cln_pkg.sv -----
package cln_pkg;

  localparam int IN_W       = 63;
  localparam int BCD_DIGITS = 19;
  localparam int BCD_W      = BCD_DIGITS * 4;
  localparam int PAIRS      = (BCD_DIGITS + 1) / 2;
  localparam int GROUPS     = 2;
  localparam int GROUP_LEN  = PAIRS / GROUPS;
  localparam int PAIR_W     = 5;
  localparam int GROUP_W    = 7;
  localparam int TOTAL_W    = 8;
  localparam int MULT10_CNT = 26;
  // entry stage, one cell per input bit, three summing stages
  localparam int LATENCY    = IN_W + 4;

  localparam logic [IN_W-1:0] AMEX_A_LO   = 63'd340000000000000;
  localparam logic [IN_W-1:0] AMEX_A_HI   = 63'd349999999999999;
  localparam logic [IN_W-1:0] AMEX_B_LO   = 63'd370000000000000;
  localparam logic [IN_W-1:0] AMEX_B_HI   = 63'd379999999999999;
  localparam logic [IN_W-1:0] MASTER_LO   = 63'd5100000000000000;
  localparam logic [IN_W-1:0] MASTER_HI   = 63'd5599999999999999;
  localparam logic [IN_W-1:0] VISA16_LO   = 63'd4000000000000000;
  localparam logic [IN_W-1:0] VISA16_HI   = 63'd4999999999999999;
  localparam logic [IN_W-1:0] VISA13_LO   = 63'd4000000000000;
  localparam logic [IN_W-1:0] VISA13_HI   = 63'd4999999999999;

  typedef enum logic [1:0] {
    KIND_INVALID = 2'd0,
    KIND_AMEX    = 2'd1,
    KIND_MASTER  = 2'd2,
    KIND_VISA    = 2'd3
  } card_kind_t;

  typedef struct packed {
    card_kind_t        kind;
    logic [IN_W-1:0]   bin;
    logic [BCD_W-1:0]  bcd;
  } cln_data_t;

  function automatic logic [3:0] dabble_adjust(input logic [3:0] d);
    logic [3:0] r;
    r = (d >= 4'd5) ? d + 4'd3 : d;
    return r;
  endfunction

  // doubled digit folded back to a single digit
  function automatic logic [3:0] luhn_double(input logic [3:0] d);
    logic [4:0] t;
    t = {d, 1'b0};
    if (t > 5'd9) begin
      t = t - 5'd9;
    end
    return t[3:0];
  endfunction

  function automatic logic is_mult10(input logic [TOTAL_W-1:0] s);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < MULT10_CNT; k++) begin
      if (s == TOTAL_W'(k * 10)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

// ----- design/cln_class.sv -----
module cln_class (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept_i,
  input  logic [cln_pkg::IN_W-1:0]  number_i,
  output logic                      valid_o,
  output cln_pkg::cln_data_t        data_o
);
  import cln_pkg::*;

  logic       valid_r;
  cln_data_t  data_r;
  cln_data_t  data_nxt;
  card_kind_t kind;

  function automatic logic in_rng(input logic [IN_W-1:0] v, input logic [IN_W-1:0] lo,
                                  input logic [IN_W-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  always_comb begin
    kind = KIND_INVALID;
    if (in_rng(number_i, MASTER_LO, MASTER_HI)) begin
      kind = KIND_MASTER;
    end else if (in_rng(number_i, AMEX_A_LO, AMEX_A_HI) ||
                 in_rng(number_i, AMEX_B_LO, AMEX_B_HI)) begin
      kind = KIND_AMEX;
    end else if (in_rng(number_i, VISA16_LO, VISA16_HI) ||
                 in_rng(number_i, VISA13_LO, VISA13_HI)) begin
      kind = KIND_VISA;
    end
    data_nxt.kind = kind;
    data_nxt.bin  = number_i;
    data_nxt.bcd  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

// ----- design/cln_cell.sv -----
module cln_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_i,
  input  cln_pkg::cln_data_t data_i,
  output logic               valid_o,
  output cln_pkg::cln_data_t data_o
);
  import cln_pkg::*;

  logic             valid_r;
  cln_data_t        data_r;
  cln_data_t        data_nxt;
  logic [BCD_W-1:0] adj;

  // one double-dabble step: correct each digit, then shift in the next binary bit
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[i*4 +: 4] = dabble_adjust(data_i.bcd[i*4 +: 4]);
    end
    data_nxt.kind = data_i.kind;
    data_nxt.bcd  = {adj[BCD_W-2:0], data_i.bin[IN_W-1]};
    data_nxt.bin  = {data_i.bin[IN_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

// ----- design/cln_luhn.sv -----
module cln_luhn (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  input  cln_pkg::cln_data_t  data_i,
  output logic                valid_o,
  output cln_pkg::card_kind_t kind_o,
  output logic                ok_o
);
  import cln_pkg::*;

  logic [PAIRS*8-1:0]  digits;
  logic [PAIR_W-1:0]   pair_nxt [PAIRS];
  logic [PAIR_W-1:0]   pair_r   [PAIRS];
  logic [GROUP_W-1:0]  grp_nxt  [GROUPS];
  logic [GROUP_W-1:0]  grp_r    [GROUPS];
  logic [TOTAL_W-1:0]  total;
  logic                ok_nxt;
  card_kind_t          kind_a_r;
  card_kind_t          kind_b_r;
  card_kind_t          kind_r;
  card_kind_t          kind_nxt;
  logic                ok_r;
  logic                vld_a_r;
  logic                vld_b_r;
  logic                vld_r;

  // pad to an even digit count so every pair has an odd-position digit
  assign digits = {{(PAIRS*8-BCD_W){1'b0}}, data_i.bcd};

  always_comb begin
    for (int p = 0; p < PAIRS; p++) begin
      pair_nxt[p] = PAIR_W'(digits[p*8 +: 4]) + PAIR_W'(luhn_double(digits[p*8+4 +: 4]));
    end
  end

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < GROUP_LEN; j++) begin
        grp_nxt[g] = grp_nxt[g] + GROUP_W'(pair_r[g*GROUP_LEN + j]);
      end
    end
  end

  always_comb begin
    total = TOTAL_W'(grp_r[0]) + TOTAL_W'(grp_r[1]);
    ok_nxt = is_mult10(total);
    kind_nxt = ok_nxt ? kind_b_r : KIND_INVALID;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      vld_a_r <= valid_i;
      vld_b_r <= vld_a_r;
      vld_r   <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    pair_r   <= pair_nxt;
    kind_a_r <= data_i.kind;
    grp_r    <= grp_nxt;
    kind_b_r <= kind_a_r;
    kind_r   <= kind_nxt;
    ok_r     <= ok_nxt;
  end

  assign valid_o = vld_r;
  assign kind_o  = kind_r;
  assign ok_o    = ok_r;

endmodule

// ----- design/card_number_luhn_classifier_top.sv -----
// Luhn mod-10 check and card range classifier. One card number is taken per clock
// whenever start is high; busy is always low, so items may follow back to back.
// Each result appears in input order, for one cycle with out_valid high, after
// one entry stage for the range compares, 63 double-dabble cells (one per input
// bit) and three digit-summing stages. The receiver cannot stall the block, so
// every result must be taken when strobed.
module card_number_luhn_classifier_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [cln_pkg::IN_W-1:0]  in_card_number,
  output logic                      out_valid,
  output logic [1:0]                out_card_kind,
  output logic                      out_checksum_ok
);
  import cln_pkg::*;

  logic       accept;
  logic       valid_c [IN_W+1];
  cln_data_t  data_c  [IN_W+1];
  card_kind_t kind;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  cln_class u_class (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept_i (accept),
    .number_i (in_card_number),
    .valid_o  (valid_c[0]),
    .data_o   (data_c[0])
  );

  for (genvar g = 0; g < IN_W; g++) begin : g_cell
    cln_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (valid_c[g]),
      .data_i  (data_c[g]),
      .valid_o (valid_c[g+1]),
      .data_o  (data_c[g+1])
    );
  end

  cln_luhn u_luhn (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (valid_c[IN_W]),
    .data_i  (data_c[IN_W]),
    .valid_o (out_valid),
    .kind_o  (kind),
    .ok_o    (out_checksum_ok)
  );

  assign out_card_kind = kind;

endmodule

// ----- design/cln_checker.sv -----
module cln_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic [cln_pkg::IN_W-1:0]  in_card_number,
  input logic                      out_valid,
  input logic [1:0]                out_card_kind,
  input logic                      out_checksum_ok
);
  import cln_pkg::*;

  // every transfer produces a result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("result missing after transfer");

  // no result without an earlier transfer
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##LATENCY !out_valid)
    else $error("result without transfer");

  a_kind_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_card_kind != 2'(KIND_INVALID))) |-> out_checksum_ok)
    else $error("card kind reported with failing checksum");

  // zero input always passes the checksum and matches no range
  a_zero_input: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_card_number == '0)) |->
      ##LATENCY (out_checksum_ok && (out_card_kind == 2'(KIND_INVALID))))
    else $error("zero input misclassified");

endmodule

bind card_number_luhn_classifier_top cln_checker u_cln_checker (.*);
